[sv/bin_norm_pkg.sv]
// Shared types, codes and defaults of the binned intensity normaliser.
// Has no dependencies; every other file of the block but bin_norm_fifo imports it.
`default_nettype none

package bin_norm_pkg;

  localparam int RINGS_DEF      = 64;
  localparam int DIST_BINS_DEF  = 256;
  localparam int COUNT_BITS_DEF = 20;

  // Width of every dividend handled by the shared divider.
  localparam int DVD_W = 40;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  localparam logic [14:0] TM_RST = 15'd25600;
  localparam logic [14:0] TS_RST = 15'd5120;
  localparam logic [7:0]  SF_RST = 8'd3;

  typedef enum logic [1:0] {
    OP_ACC  = 2'd0,
    OP_NORM = 2'd1,
    OP_CLR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_TM = 2'd0,
    CFG_TS = 2'd1,
    CFG_SF = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [14:0] tm;
    logic [14:0] ts;
    logic [7:0]  sf;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_MU,
    ST_MNQ,
    ST_MSS,
    ST_SQ,
    ST_SIG,
    ST_PRD,
    ST_YDV
  } st_t;

endpackage

`default_nettype wire

[sv/bin_norm_fifo.sv]
// Two-entry queue between the front and the back of the normaliser.
// Depends on nothing but the item width handed down.
`default_nettype none

module bin_norm_fifo #(
  parameter int W = 24
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic              valid,
  output logic [W-1:0]      rdata
);

  logic [W-1:0] ent_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rdata = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

[sv/bin_norm_front.sv]
// Front of the normaliser: takes input transfers, saturates ring and
// distance, forms the bin index and queues the item. Uses bin_norm_pkg.
`default_nettype none

module bin_norm_front
  import bin_norm_pkg::*;
#(
  parameter int RINGS     = RINGS_DEF,
  parameter int DIST_BINS = DIST_BINS_DEF,
  parameter int IDX_W     = $clog2(RINGS * DIST_BINS)
) (
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [1:0]        in_op,
  input  wire logic [5:0]        in_ring,
  input  wire logic [7:0]        in_dist,
  input  wire logic [7:0]        in_x,
  input  wire logic              clr_done,
  input  wire logic              q_full,
  output logic                   q_push,
  output logic [IDX_W+9:0]       q_wdata
);

  logic [31:0]      ring_s, dist_s;
  logic [IDX_W-1:0] idx;
  logic             op_ok;

  always_comb begin
    ring_s = (32'(in_ring) > 32'(RINGS - 1)) ? 32'(RINGS - 1) : 32'(in_ring);
    dist_s = (32'(in_dist) > 32'(DIST_BINS - 1)) ? 32'(DIST_BINS - 1) : 32'(in_dist);
    idx    = IDX_W'(ring_s * 32'(DIST_BINS) + dist_s);
    // The undefined operation code is taken and dropped here.
    op_ok  = (in_op == OP_ACC) || (in_op == OP_NORM) || (in_op == OP_CLR);
  end

  assign in_tready = clr_done && !q_full;
  assign q_push    = in_tvalid && in_tready && op_ok;
  assign q_wdata   = {in_op, idx, in_x};

endmodule

`default_nettype wire

[sv/bin_norm_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all three
// divisions of a normalise item. Uses bin_norm_pkg for the dividend width.
`default_nettype none

module bin_norm_div
  import bin_norm_pkg::*;
#(
  parameter int DVS_W = 28
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dvd,
  input  wire logic [DVS_W-1:0] dvs,
  output logic                  busy,
  output logic                  done,
  output logic [DVD_W-1:0]      quo
);

  logic              busy_r, done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W:0]    rem_sh, rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dvd;
      dvs_r <= dvs;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = dvd_r;

endmodule

`default_nettype wire

[sv/bin_norm_back.sv]
// Back of the normaliser: bin statistics memory, clearing pass and the
// sequencer for accumulate, clear and normalise. Uses bin_norm_pkg, bin_norm_div.
`default_nettype none

module bin_norm_back
  import bin_norm_pkg::*;
#(
  parameter int RINGS      = RINGS_DEF,
  parameter int DIST_BINS  = DIST_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int IDX_W      = $clog2(RINGS * DIST_BINS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             q_valid,
  input  wire logic [IDX_W+9:0] q_rdata,
  output logic                  q_pop,
  output logic                  clr_done,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [15:0]           out_y,
  output logic                  out_empty
);

  localparam int NB    = RINGS * DIST_BINS;
  localparam int C     = COUNT_BITS;
  localparam int SUM_W = C + 8;
  localparam int SQ_W  = C + 16;
  localparam int MEM_W = C + SUM_W + SQ_W;
  localparam int D_W   = 2 * C + 16;
  localparam int DVS_W = C + 8;

  logic [MEM_W-1:0] mem [NB];
  logic [MEM_W-1:0] rd_q;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  logic [MEM_W-1:0] mem_wd;

  st_t st_r, st_nxt;

  logic [IDX_W-1:0] clr_cnt_r;
  logic             clr_done_r;
  logic [1:0]       op_r;
  logic [IDX_W-1:0] idx_r;
  logic [7:0]       x_r;
  logic [C-1:0]     n_r;
  logic [SUM_W-1:0] s_r;
  logic [15:0]      mu_r;
  logic [63:0]      pa_r, pp_r;
  logic [SUM_W-1:0] pb_r;
  logic [5:0]       cnt_r;
  logic [D_W-1:0]   nq_r;
  logic [63:0]      sv_r, sres_r, sbit_r;
  logic [4:0]       k_r;
  logic [15:0]      sig_r;
  logic             neg_r;
  logic [30:0]      prod_r;
  logic             out_v_r, out_e_r;
  logic [15:0]      out_y_r;

  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;

  // Decoded queue head and memory word.
  logic [1:0]       h_op;
  logic [IDX_W-1:0] h_idx;
  logic [7:0]       h_x;
  logic [C-1:0]     rd_n;
  logic [SUM_W-1:0] rd_s;
  logic [SQ_W-1:0]  rd_sq;

  logic [63:0]      pp_nxt;
  logic [D_W-1:0]   ss_w, d_w;
  logic [63:0]      d64;
  logic [4:0]       k_w;
  logic [63:0]      st_t_sum;
  logic             sq_ge;
  logic [63:0]      sres_nxt, sv_nxt;
  logic [15:0]      sig_w;
  logic signed [16:0] diff;
  logic [15:0]      mag;
  logic signed [33:0] y_shift, y_scale;

  assign {h_op, h_idx, h_x} = q_rdata;
  assign rd_n  = rd_q[C-1:0];
  assign rd_s  = rd_q[C+SUM_W-1:C];
  assign rd_sq = rd_q[MEM_W-1:C+SUM_W];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  bin_norm_div #(.DVS_W(DVS_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  function automatic logic [15:0] clamp_y(input logic signed [33:0] y,
                                          input logic [14:0] tm);
    logic signed [33:0] hi;
    hi = $signed({18'd0, tm, 1'b0});
    if (y < 0) begin
      clamp_y = 16'd0;
    end else if (y > hi) begin
      clamp_y = {tm, 1'b0};
    end else begin
      clamp_y = y[15:0];
    end
  endfunction

  // Datapath arithmetic shared by several states.
  always_comb begin
    pp_nxt = pp_r + (pb_r[0] ? pa_r : 64'd0);
    ss_w   = pp_nxt[D_W-1:0];
    d_w    = (nq_r > ss_w) ? (nq_r - ss_w) : '0;
    d64    = 64'(d_w);
    k_w    = 5'd0;
    for (int kk = 2; kk <= 16; kk += 2) begin
      if ((d64 >> (64 - kk)) == 64'd0) begin
        k_w = 5'(kk);
      end
    end
    st_t_sum = sres_r + sbit_r;
    sq_ge    = (sv_r >= st_t_sum);
    sres_nxt = sq_ge ? ((sres_r >> 1) + sbit_r) : (sres_r >> 1);
    sv_nxt   = sq_ge ? (sv_r - st_t_sum) : sv_r;
    sig_w    = div_q[15:0];
    diff     = $signed({1'b0, x_r, 8'd0}) - $signed({1'b0, mu_r});
    mag      = diff[16] ? 16'(-diff) : diff[15:0];
    y_shift  = 34'(diff) + $signed({19'd0, cfg.tm});
    y_scale  = (neg_r ? -$signed({3'd0, div_q[30:0]}) : $signed({3'd0, div_q[30:0]}))
               + $signed({19'd0, cfg.tm});
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLR: begin
        if (clr_cnt_r == IDX_W'(NB - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid && !out_v_r) begin
          st_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (op_r == OP_NORM && rd_n != '0) begin
          st_nxt = ST_MU;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_MU:  if (div_done) st_nxt = ST_MNQ;
      ST_MNQ: if (cnt_r == 6'd1) st_nxt = ST_MSS;
      ST_MSS: if (cnt_r == 6'd1) st_nxt = ST_SQ;
      ST_SQ:  if (cnt_r == 6'd1) st_nxt = ST_SIG;
      ST_SIG: begin
        if (div_done) begin
          st_nxt = (sig_w == 16'd0 || sig_w < {8'd0, cfg.sf}) ? ST_IDLE : ST_PRD;
        end
      end
      ST_PRD: st_nxt = ST_YDV;
      ST_YDV: if (div_done) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control outputs: queue, memory ports and divider start.
  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = idx_r;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = h_idx;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (st_r)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
      end
      ST_IDLE: begin
        if (q_valid && !out_v_r) begin
          q_pop  = 1'b1;
          mem_re = 1'b1;
        end
      end
      ST_RD: begin
        if (op_r == OP_ACC && rd_n != '1) begin
          mem_we = 1'b1;
          mem_wd = {rd_sq + SQ_W'({8'd0, x_r} * {8'd0, x_r}), rd_s + SUM_W'(x_r),
                    rd_n + 1'b1};
        end else if (op_r == OP_CLR) begin
          mem_we = 1'b1;
        end else if (op_r == OP_NORM && rd_n != '0) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'({rd_s, 8'd0});
          div_dvs   = DVS_W'(rd_n);
        end
      end
      ST_SQ: begin
        if (cnt_r == 6'd1) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'({sres_nxt[31:0], 8'd0});
          div_dvs   = DVS_W'(n_r) << k_r[4:1];
        end
      end
      ST_PRD: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(prod_r);
        div_dvs   = DVS_W'(sig_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        op_r  <= h_op;
        idx_r <= h_idx;
        x_r   <= h_x;
      end
      ST_RD: begin
        n_r <= rd_n;
        s_r <= rd_s;
        // Product n * sum of squares is formed first.
        pa_r <= 64'(rd_sq);
        pb_r <= SUM_W'(rd_n);
        pp_r <= '0;
      end
      ST_MU: begin
        mu_r  <= div_q[15:0];
        cnt_r <= 6'(C);
      end
      ST_MNQ: begin
        pp_r  <= pp_nxt;
        pa_r  <= pa_r << 1;
        pb_r  <= pb_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          nq_r  <= pp_nxt[D_W-1:0];
          pa_r  <= 64'(s_r);
          pb_r  <= s_r;
          pp_r  <= '0;
          cnt_r <= 6'(SUM_W);
        end
      end
      ST_MSS: begin
        pp_r  <= pp_nxt;
        pa_r  <= pa_r << 1;
        pb_r  <= pb_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          k_r    <= k_w;
          sv_r   <= d64 << k_w;
          sres_r <= '0;
          sbit_r <= 64'd1 << 62;
          cnt_r  <= 6'd32;
        end
      end
      ST_SQ: begin
        sv_r   <= sv_nxt;
        sres_r <= sres_nxt;
        sbit_r <= sbit_r >> 2;
        cnt_r  <= cnt_r - 1'b1;
      end
      ST_SIG: begin
        sig_r  <= sig_w;
        neg_r  <= diff[16];
        prod_r <= mag * cfg.ts;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLR;
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
      out_v_r    <= 1'b0;
      out_e_r    <= 1'b0;
      out_y_r    <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(NB - 1)) begin
          clr_done_r <= 1'b1;
        end
      end
      if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      if (st_r == ST_RD && op_r == OP_NORM && rd_n == '0) begin
        // Empty bin: the raw intensity goes out in the upper byte, low byte zero.
        out_v_r <= 1'b1;
        out_e_r <= 1'b1;
        out_y_r <= {x_r, 8'd0};
      end else if (st_r == ST_SIG && div_done &&
                   (sig_w == 16'd0 || sig_w < {8'd0, cfg.sf})) begin
        out_v_r <= 1'b1;
        out_e_r <= 1'b0;
        out_y_r <= clamp_y(y_shift, cfg.tm);
      end else if (st_r == ST_YDV && div_done) begin
        out_v_r <= 1'b1;
        out_e_r <= 1'b0;
        out_y_r <= clamp_y(y_scale, cfg.tm);
      end
    end
  end

  assign clr_done   = clr_done_r;
  assign out_tvalid = out_v_r;
  assign out_y      = out_y_r;
  assign out_empty  = out_e_r;

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_no_pop_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done_r |-> !q_pop)
    else $error("item taken during clearing pass");

  a_empty_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_e_r |-> out_y_r[7:0] == 8'd0)
    else $error("empty-bin result is not a raw intensity");

endmodule

`default_nettype wire

[sv/binned_intensity_normalizer_top.sv]
// Binned intensity normaliser: a normalise item runs three divisions, a square
// root and two bit-serial products on the shared datapath; one item at a time.
// Accumulate and clear give no result. Reset (rst_n, synchronous) restores
// the configuration and starts a clearing pass over all RINGS*DIST_BINS bins
// (16384 by default) during which in_tready stays low.
`default_nettype none

module binned_intensity_normalizer_top
  import bin_norm_pkg::*;
#(
  parameter int RINGS      = RINGS_DEF,
  parameter int DIST_BINS  = DIST_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // ring[5:0], dist_bin[13:6], intensity[21:14]
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // normalized_intensity[15:0]
  output logic [0:0]       out_tuser,  // bin_was_empty[0]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [14:0] cfg_wdata
);

  localparam int IDX_W = $clog2(RINGS * DIST_BINS);

  cfg_t             cfg_r;
  logic             q_push, q_full, q_pop, q_valid, clr_done;
  logic [IDX_W+9:0] q_wdata, q_rdata;
  logic             out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tm <= TM_RST;
      cfg_r.ts <= TS_RST;
      cfg_r.sf <= SF_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TM:  cfg_r.tm <= cfg_wdata;
        CFG_TS:  cfg_r.ts <= cfg_wdata;
        CFG_SF:  cfg_r.sf <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  bin_norm_front #(
    .RINGS(RINGS), .DIST_BINS(DIST_BINS), .IDX_W(IDX_W)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .in_ring   (in_tdata[5:0]),
    .in_dist   (in_tdata[13:6]),
    .in_x      (in_tdata[21:14]),
    .clr_done  (clr_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  bin_norm_fifo #(.W(IDX_W + 10)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  bin_norm_back #(
    .RINGS(RINGS), .DIST_BINS(DIST_BINS), .COUNT_BITS(COUNT_BITS), .IDX_W(IDX_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .clr_done   (clr_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_y      (out_tdata),
    .out_empty  (out_empty)
  );

  assign out_tuser = out_empty;

endmodule

`default_nettype wire

[tb/sv/binned_intensity_normalizer_top_test.sv]
// Self-checking testbench of the binned intensity normaliser top level.
// Depends on bin_norm_pkg and binned_intensity_normalizer_top only.
`timescale 1ns / 1ps

module binned_intensity_normalizer_top_test;
  import bin_norm_pkg::*;

  localparam logic [1:0] OP_UNDEF = 2'd3;
  localparam int NBINS = RINGS_DEF * DIST_BINS_DEF;
  localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

  typedef struct {
    logic [1:0] op;
    logic [5:0] ring;
    logic [7:0] col;
    logic [7:0] x;
  } point_t;

  typedef struct {
    logic [15:0] level;
    logic        empty;
  } norm_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [14:0] cfg_wdata = '0;

  binned_intensity_normalizer_top dut (.*);

  always #1 clk = ~clk;

  // Local copy of the per-bin statistics and the configuration.
  logic [19:0] bin_n [NBINS];
  logic [63:0] bin_s [NBINS];
  logic [63:0] bin_q [NBINS];
  logic [14:0] tgt_mean = TM_RST;
  logic [14:0] tgt_std = TS_RST;
  logic [7:0]  dev_floor = SF_RST;

  point_t points_pending[$];
  norm_t  norm_expected[$];
  int     mismatches = 0;
  int     send_gap_max = 5;
  int     recv_stall_max = 5;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void apply_point(point_t p);
    int          idx;
    logic [63:0] n, s, q, nq, ss, d, r, den;
    longint      mu, sigma, diff, y, hi;
    int          k;
    norm_t       e;
    idx = int'({p.ring, p.col});
    if (p.op == OP_ACC) begin
      if (bin_n[idx] < COUNT_MAX) begin
        bin_n[idx] = bin_n[idx] + 1;
        bin_s[idx] = bin_s[idx] + p.x;
        bin_q[idx] = bin_q[idx] + p.x * p.x;
      end
    end else if (p.op == OP_CLR) begin
      bin_n[idx] = 0;
      bin_s[idx] = 0;
      bin_q[idx] = 0;
    end else if (p.op == OP_NORM) begin
      n = bin_n[idx];
      if (n == 0) begin
        e.level = {p.x, 8'h00};
        e.empty = 1'b1;
      end else begin
        s = bin_s[idx];
        q = bin_q[idx];
        mu = longint'((s << 8) / n);
        nq = n * q;
        ss = s * s;
        d = (nq > ss) ? nq - ss : 64'd0;
        // Scale the variance up by at most 16 bits, as far as 64 bits allow, to keep precision.
        k = 16;
        while (k > 0 && (d >> (64 - k)) != 0) k = k - 2;
        r = int_sqrt(d << k);
        den = n << (k / 2);
        sigma = longint'((r << 8) / den);
        diff = longint'({48'd0, p.x, 8'h00}) - mu;
        if (sigma == 0 || sigma < longint'(dev_floor))
          y = diff + longint'(tgt_mean);
        else
          y = (diff * longint'(tgt_std)) / sigma + longint'(tgt_mean);
        hi = 2 * longint'(tgt_mean);
        if (y < 0) y = 0;
        if (y > hi) y = hi;
        e.level = y[15:0];
        e.empty = 1'b0;
      end
      norm_expected = {norm_expected, e};
    end
  endfunction

  // Sender: one transfer per pending point, with a random gap before each.
  point_t cur_point;
  int     send_gap = 0;
  always @(posedge clk) begin
    logic fire, next_valid;
    if (rst_n) begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        apply_point(cur_point);
        send_gap = $urandom_range(0, send_gap_max);
      end
      next_valid = in_tvalid && !fire;
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (points_pending.size() > 0) begin
          cur_point = points_pending.pop_front();
          in_tdata <= {2'b00, cur_point.x, cur_point.col, cur_point.ring};
          in_tuser <= cur_point.op;
          next_valid = 1'b1;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // Receiver: random stalls on out_tready, results checked in order.
  int recv_stall = 0;
  always @(posedge clk) begin
    norm_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (norm_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: level %0d empty %0b", out_tdata, out_tuser);
        end else begin
          e = norm_expected.pop_front();
          if (out_tdata !== e.level || out_tuser[0] !== e.empty) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: level exp %0d got %0d, empty exp %0b got %0b",
                       e.level, out_tdata, e.empty, out_tuser);
          end
        end
        recv_stall = $urandom_range(0, recv_stall_max);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [14:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_TM: tgt_mean = v;
      CFG_TS: tgt_std = v;
      default: dev_floor = v[7:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_targets(logic [14:0] tm, logic [14:0] ts, logic [7:0] sf);
    write_reg(CFG_TM, tm);
    write_reg(CFG_TS, ts);
    write_reg(CFG_SF, {7'd0, sf});
  endtask

  // Waits until everything sent has been answered, then covers the
  // latency of a trailing accumulate or clear that gives no result.
  task automatic wait_drained();
    while (points_pending.size() > 0 || in_tvalid || norm_expected.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic queue_point(logic [1:0] op, logic [5:0] ring, logic [7:0] col,
                             logic [7:0] x);
    point_t p;
    p.op = op;
    p.ring = ring;
    p.col = col;
    p.x = x;
    points_pending = {points_pending, p};
  endtask

  // Random points concentrated on a few bins so that statistics build up.
  task automatic queue_random(int count);
    logic [13:0] hot_bins [16];
    logic [13:0] b;
    logic [1:0]  op;
    int          sel;
    foreach (hot_bins[i]) hot_bins[i] = 14'($urandom_range(0, NBINS - 1));
    hot_bins[0] = '0;
    hot_bins[1] = '1;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) op = OP_ACC;
      else if (sel < 85) op = OP_NORM;
      else if (sel < 95) op = OP_CLR;
      else op = OP_UNDEF;
      if ($urandom_range(0, 99) < 85) b = hot_bins[$urandom_range(0, 15)];
      else b = 14'($urandom_range(0, NBINS - 1));
      queue_point(op, b[13:8], b[7:0], 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    foreach (bin_n[i]) begin
      bin_n[i] = 0;
      bin_s[i] = 0;
      bin_q[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_targets(TM_RST, TS_RST, SF_RST);

    // Directed: empty bins, undefined op, spread and flat bins, clear.
    queue_point(OP_NORM, 6'd0, 8'd0, 8'd0);
    queue_point(OP_NORM, 6'd63, 8'd255, 8'd255);
    queue_point(OP_UNDEF, 6'd0, 8'd0, 8'd9);
    queue_point(OP_ACC, 6'd0, 8'd0, 8'd0);
    queue_point(OP_ACC, 6'd0, 8'd0, 8'd255);
    queue_point(OP_ACC, 6'd0, 8'd0, 8'd128);
    queue_point(OP_NORM, 6'd0, 8'd0, 8'd255);
    queue_point(OP_NORM, 6'd0, 8'd0, 8'd0);
    repeat (3) queue_point(OP_ACC, 6'd63, 8'd255, 8'd200);
    queue_point(OP_NORM, 6'd63, 8'd255, 8'd200);
    queue_point(OP_NORM, 6'd63, 8'd255, 8'd0);
    queue_point(OP_CLR, 6'd0, 8'd0, 8'd0);
    queue_point(OP_NORM, 6'd0, 8'd0, 8'd77);
    queue_random(250);
    wait_drained();

    // Extreme settings; a flat bin with a zero floor takes the shift path.
    set_targets(15'h7FFF, 15'h7FFF, 8'hFF);
    queue_random(270);
    wait_drained();

    set_targets('0, '0, '0);
    queue_point(OP_CLR, 6'd63, 8'd255, 8'd0);
    repeat (2) queue_point(OP_ACC, 6'd63, 8'd255, 8'd50);
    queue_point(OP_NORM, 6'd63, 8'd255, 8'd10);
    queue_random(260);
    wait_drained();

    send_gap_max = 0;
    recv_stall_max = 0;
    set_targets(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)), 8'd0);
    queue_point(OP_CLR, 6'd5, 8'd5, 8'd0);
    repeat (4) queue_point(OP_ACC, 6'd5, 8'd5, 8'd33);
    queue_point(OP_NORM, 6'd5, 8'd5, 8'd34);
    queue_random(260);
    wait_drained();

    send_gap_max = 5;
    recv_stall_max = 5;
    set_targets(15'd1, 15'h7FFF, 8'd1);
    queue_random(270);
    wait_drained();

    set_targets(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                8'($urandom_range(0, 255)));
    queue_random(270);
    wait_drained();

    if (mismatches == 0 && norm_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
